// File: hw/rtl/c2cc_pkg.sv
// ----------------------------------------------------------------------------
// c2cc_pkg
// Shared widths, constants and the arctangent table for the Cartesian to
// cylinder coordinate pipeline and its checker.
// ----------------------------------------------------------------------------
package c2cc_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = COORD_WIDTH - 4;

    // Configuration register file.
    localparam int REG_W     = 16;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] IDX_INV_HEIGHT = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] IDX_INV_RADIUS = REG_IDX_W'(1);
    localparam logic [REG_W-1:0]     INV_HEIGHT_RESET = REG_W'(256);
    localparam logic [REG_W-1:0]     INV_RADIUS_RESET = REG_W'(512);

    // CORDIC datapath.
    localparam int GUARD_BITS = 8;
    localparam int XW         = COORD_WIDTH + GUARD_BITS + 3;
    localparam int ACC_W      = 32;
    localparam int ASHIFT     = ACC_W - COORD_WIDTH;
    localparam int ANG_RND    = (ASHIFT > 0) ? (1 << (ASHIFT - 1)) : 0;
    localparam logic [ACC_W-1:0] ACC_HALF_TURN = {1'b1, {(ACC_W-1){1'b0}}};

    // Gain correction 1/K in Q0.20, then reciprocal radius in Q8.8.
    localparam int GAIN_FRAC = 20;
    localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q20 = GAIN_FRAC'(636751);
    localparam int P1_W      = XW - 1 + GAIN_FRAC;
    localparam int P2_W      = XW + REG_W;
    localparam int RAD_SHIFT = 8 + GUARD_BITS;

    // Axial path.
    localparam int AXP_W = COORD_WIDTH + REG_W + 1;
    localparam int AXS_W = AXP_W + 1;
    localparam logic signed [AXS_W-1:0] AX_HALF = AXS_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [AXS_W-1:0] AX_MAX  = AXS_W'((1 << (COORD_WIDTH - 1)) - 1);
    localparam logic signed [AXS_W-1:0] AX_MIN  = -AXS_W'(1 << (COORD_WIDTH - 1));

    // Stage 0 is the half-turn pre-rotation, then one stage per micro-rotation,
    // then gain product, rounding, radius product and the output stage.
    localparam int LAST_STAGE = CORDIC_STAGES + 4;
    localparam int LATENCY    = LAST_STAGE + 1;

    // Arctangent of 2^-i, full turn = 2^32.
    function automatic logic [ACC_W-1:0] atan_turn(input int i);
        logic [ACC_W-1:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/cartesian_to_cylindrical_coords.sv
// ----------------------------------------------------------------------------
// cartesian_to_cylindrical_coords
// Maps a point (x, axial y, z) to normalized cylinder coordinates: axial
// fraction, azimuth as a binary angle and radial fraction, using a fully
// pipelined CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   ------------------------  ---------------------------------------
//  point     start, busy (always low)  x_coord, y_coord, z_coord
//  result    done (one-cycle strobe)   axial_fraction, angle, radial_fraction
//  config    wr_en                     wr_index, wr_data
//
// One point is taken every cycle. A result passes through one pre-rotation
// stage, one stage per micro-rotation, two stages for the gain correction and
// two for the radius scaling. Reset clears the valid bits and loads the
// register defaults; no clearing pass is needed. The receiver cannot stall,
// so the pipeline never holds.
// ----------------------------------------------------------------------------
module cartesian_to_cylindrical_coords
    import c2cc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic signed [COORD_WIDTH-1:0] z_coord,

    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] axial_fraction,
    output logic        [COORD_WIDTH-1:0] angle,
    output logic        [COORD_WIDTH-1:0] radial_fraction,

    input  logic                          wr_en,
    input  logic        [REG_IDX_W-1:0]   wr_index,
    input  logic        [REG_W-1:0]       wr_data
);

    logic [REG_W-1:0] inv_height_reg;
    logic [REG_W-1:0] inv_radius_reg;

    logic             accept;
    logic [LAST_STAGE:0] vld_reg;

    logic signed [XW-1:0]    x_in;
    logic signed [XW-1:0]    z_in;
    logic signed [XW-1:0]    x0_next;
    logic signed [XW-1:0]    z0_next;
    logic        [ACC_W-1:0] acc0_next;

    logic signed [XW-1:0]    xc_reg  [0:CORDIC_STAGES];
    logic signed [XW-1:0]    zc_reg  [0:CORDIC_STAGES];
    logic        [ACC_W-1:0] acc_reg [0:CORDIC_STAGES];
    logic                    zero_reg [0:LAST_STAGE-1];

    logic        [XW-2:0]    x_pos;
    logic        [ACC_W-1:0] acc_rnd;
    logic        [P1_W-1:0]  prod1_reg;
    logic        [P1_W:0]    m_sum;
    logic        [XW-1:0]    m_reg;
    logic        [P2_W-1:0]  prod2_reg;
    logic        [P2_W:0]    r_sum;
    logic        [XW:0]      r_full;
    logic        [COORD_WIDTH-1:0] r_sat;
    logic        [COORD_WIDTH-1:0] ang_reg [0:2];

    logic signed [AXP_W-1:0] ax_prod_reg;
    logic signed [AXS_W-1:0] ax_sum;
    logic signed [COORD_WIDTH-1:0] ax_sat;
    logic signed [COORD_WIDTH-1:0] axial_reg [1:LAST_STAGE-1];

    logic signed [COORD_WIDTH-1:0] axial_out_reg;
    logic        [COORD_WIDTH-1:0] angle_out_reg;
    logic        [COORD_WIDTH-1:0] radial_out_reg;

    // Every cycle can take a point.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_height_reg <= INV_HEIGHT_RESET;
            inv_radius_reg <= INV_RADIUS_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                IDX_INV_HEIGHT: inv_height_reg <= wr_data;
                IDX_INV_RADIUS: inv_radius_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAST_STAGE-1:0], accept};
        end
    end

    // A point left of the axis is turned by a half turn first, so the
    // micro-rotations only have to cover the right half plane.
    always_comb
    begin
        x_in = XW'(x_coord) <<< GUARD_BITS;
        z_in = XW'(z_coord) <<< GUARD_BITS;
        if (x_coord[COORD_WIDTH-1])
        begin
            x0_next   = -x_in;
            z0_next   = -z_in;
            acc0_next = ACC_HALF_TURN;
        end
        else
        begin
            x0_next   = x_in;
            z0_next   = z_in;
            acc0_next = '0;
        end
    end

    always_comb
    begin
        x_pos   = xc_reg[CORDIC_STAGES][XW-1] ? '0 : xc_reg[CORDIC_STAGES][XW-2:0];
        acc_rnd = acc_reg[CORDIC_STAGES] + ACC_W'(ANG_RND);
        m_sum   = {1'b0, prod1_reg} + (P1_W+1)'(1 << (GAIN_FRAC - 1));
        r_sum   = {1'b0, prod2_reg} + (P2_W+1)'(1 << (RAD_SHIFT - 1));
        r_full  = r_sum[P2_W:RAD_SHIFT];
        r_sat   = (|r_full[XW:COORD_WIDTH]) ? '1 : r_full[COORD_WIDTH-1:0];
    end

    // Round half up after the Q8.8 product, then add one half.
    always_comb
    begin
        ax_sum = ((AXS_W'(ax_prod_reg) + AXS_W'(128)) >>> 8) + AX_HALF;
        if (ax_sum > AX_MAX)
        begin
            ax_sat = AX_MAX[COORD_WIDTH-1:0];
        end
        else if (ax_sum < AX_MIN)
        begin
            ax_sat = AX_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            ax_sat = ax_sum[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 0.
        xc_reg[0]   <= x0_next;
        zc_reg[0]   <= z0_next;
        acc_reg[0]  <= acc0_next;
        zero_reg[0] <= (x_coord == '0) && (z_coord == '0);
        ax_prod_reg <= AXP_W'(y_coord) * AXP_W'($signed({1'b0, inv_height_reg}));

        // One micro-rotation per stage, driving z toward zero.
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (!zc_reg[i][XW-1])
            begin
                xc_reg[i+1]  <= xc_reg[i] + (zc_reg[i] >>> i);
                zc_reg[i+1]  <= zc_reg[i] - (xc_reg[i] >>> i);
                acc_reg[i+1] <= acc_reg[i] + atan_turn(i);
            end
            else
            begin
                xc_reg[i+1]  <= xc_reg[i] - (zc_reg[i] >>> i);
                zc_reg[i+1]  <= zc_reg[i] + (xc_reg[i] >>> i);
                acc_reg[i+1] <= acc_reg[i] - atan_turn(i);
            end
        end

        for (int k = 1; k < LAST_STAGE; k++)
        begin
            zero_reg[k] <= zero_reg[k-1];
        end

        axial_reg[1] <= ax_sat;
        for (int k = 2; k < LAST_STAGE; k++)
        begin
            axial_reg[k] <= axial_reg[k-1];
        end

        // Gain correction and radius scaling.
        prod1_reg  <= P1_W'(x_pos) * P1_W'(INV_GAIN_Q20);
        ang_reg[0] <= acc_rnd[ACC_W-1:ASHIFT];
        m_reg      <= m_sum[P1_W:GAIN_FRAC];
        ang_reg[1] <= ang_reg[0];
        prod2_reg  <= P2_W'(m_reg) * P2_W'(inv_radius_reg);
        ang_reg[2] <= ang_reg[1];

        // Output stage; the origin has no direction and no distance.
        axial_out_reg  <= axial_reg[LAST_STAGE-1];
        angle_out_reg  <= zero_reg[LAST_STAGE-1] ? '0 : ang_reg[2];
        radial_out_reg <= zero_reg[LAST_STAGE-1] ? '0 : r_sat;
    end

    assign done            = vld_reg[LAST_STAGE];
    assign axial_fraction  = axial_out_reg;
    assign angle           = angle_out_reg;
    assign radial_fraction = radial_out_reg;

endmodule

// File: hw/rtl/c2cc_checker.sv
// ----------------------------------------------------------------------------
// c2cc_checker
// Port-level checks on the coordinate pipeline: fixed latency, no invented
// results and zero outputs for the origin.
// ----------------------------------------------------------------------------
module c2cc_checker
    import c2cc_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] x_coord,
    input logic signed [COORD_WIDTH-1:0] z_coord,
    input logic                          done,
    input logic        [COORD_WIDTH-1:0] angle,
    input logic        [COORD_WIDTH-1:0] radial_fraction
);

    localparam int WARM_W = $clog2(LATENCY + 1);

    logic [WARM_W-1:0] warm_cnt_reg;
    logic              warm;

    // Counts cycles since reset so that $past never looks into reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= '0;
        end
        else if (!warm)
        begin
            warm_cnt_reg <= warm_cnt_reg + WARM_W'(1);
        end
    end

    assign warm = (warm_cnt_reg == WARM_W'(LATENCY));

    // Every transfer in gives exactly one result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after point transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done) |-> $past(start && !busy, LATENCY))
        else $error("result without a matching point transfer");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !warm |-> !done || $past(start && !busy, LATENCY))
        else $error("result shortly after reset without a transfer");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && $past(x_coord == '0 && z_coord == '0, LATENCY))
        |-> (angle == '0) && (radial_fraction == '0))
        else $error("origin must give zero angle and zero radius");

endmodule

bind cartesian_to_cylindrical_coords c2cc_checker u_c2cc_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Cartesian to cylinder coordinate pipeline. A
// driver presents points from a queue with random gaps, and a predictor
// computes the axial fraction, binary angle and radial fraction of every
// accepted point. A monitor compares each result strobe with the oldest
// prediction. Phases change the reciprocal registers while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import c2cc_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int SETTLE_LIMIT = CORDIC_STAGES + 12;
    localparam int MAX_REPORTS  = 10;
    localparam int ANG_SHIFT    = 32 - COORD_WIDTH;
    localparam longint unsigned GAIN_RECIP_Q20 = 636751;

    // Indexes past the two registers; writes there must not change anything.
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_LO = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_HI = REG_IDX_W'(3);

    // Arctangent of 2^-i with a full turn of 2^32.
    localparam logic [31:0] ATAN_LUT [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] axial;
        logic        [COORD_WIDTH-1:0] angle;
        logic        [COORD_WIDTH-1:0] radial;
    } cyl_t;

    // Origin, axes in both directions, the four quadrants and field extremes.
    localparam point_t DIRECTED [0:21] = '{
        '{0, 0, 0},             '{32767, 32767, 32767}, '{-32768, -32768, -32768},
        '{32767, 0, 0},         '{-32768, 0, 0},        '{0, 0, 32767},
        '{0, 0, -32768},        '{4096, 4096, 0},       '{-4096, -4096, 0},
        '{0, 2048, 4096},       '{0, -2048, -4096},     '{-1, 1, 0},
        '{0, -1, -1},           '{1, 0, -1},            '{-1, 0, 1},
        '{32767, -32768, -32768}, '{-32768, 32767, 32767}, '{4096, 0, 4096},
        '{-4096, 0, -4096},     '{3000, -3000, -5000},  '{0, 32767, 1},
        '{0, 0, 1}
    };

    logic clk;
    logic rst_n;

    logic                          start   = 1'b0;
    logic                          busy;
    logic signed [COORD_WIDTH-1:0] x_coord = '0;
    logic signed [COORD_WIDTH-1:0] y_coord = '0;
    logic signed [COORD_WIDTH-1:0] z_coord = '0;

    logic                          done;
    logic signed [COORD_WIDTH-1:0] axial_fraction;
    logic        [COORD_WIDTH-1:0] angle;
    logic        [COORD_WIDTH-1:0] radial_fraction;

    logic                          wr_en    = 1'b0;
    logic        [REG_IDX_W-1:0]   wr_index = '0;
    logic        [REG_W-1:0]       wr_data  = '0;

    // Register values as the pipeline should see them.
    logic [REG_W-1:0] height_recip = INV_HEIGHT_RESET;
    logic [REG_W-1:0] radius_recip = INV_RADIUS_RESET;

    point_t point_q [$];
    cyl_t   expected_cyl_q [$];
    logic   point_taken = 1'b0;
    int     send_idle_pct = 0;
    int     mismatch_count = 0;
    int     cycle_count = 0;

    cartesian_to_cylindrical_coords dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .z_coord         (z_coord),
        .done            (done),
        .axial_fraction  (axial_fraction),
        .angle           (angle),
        .radial_fraction (radial_fraction),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cyl_t to_cylinder(point_t p, logic [REG_W-1:0] h_recip,
                                         logic [REG_W-1:0] r_recip);
        cyl_t              res;
        longint            prod;
        longint            q;
        longint            xc;
        longint            zc;
        longint            dx;
        longint            dz;
        longint unsigned   turn;
        longint unsigned   mag;
        longint unsigned   rad;
        logic [31:0]       acc;
        prod = longint'(p.y) * longint'(h_recip);
        q = ((prod + 128) >>> 8) + (longint'(1) <<< (FRAC_BITS - 1));
        if (q > (longint'(1) <<< (COORD_WIDTH - 1)) - 1)
            q = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        if (q < -(longint'(1) <<< (COORD_WIDTH - 1)))
            q = -(longint'(1) <<< (COORD_WIDTH - 1));
        res.axial  = q[COORD_WIDTH-1:0];
        res.angle  = '0;
        res.radial = '0;
        if (p.x != 0 || p.z != 0)
        begin
            acc = '0;
            xc = longint'(p.x) * (longint'(1) <<< GUARD_BITS);
            zc = longint'(p.z) * (longint'(1) <<< GUARD_BITS);
            // Left half plane: turn by half a turn so the CORDIC converges.
            if (xc < 0)
            begin
                xc  = -xc;
                zc  = -zc;
                acc = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
            begin
                dx = zc >>> i;
                dz = xc >>> i;
                if (zc >= 0)
                begin
                    xc  = xc + dx;
                    zc  = zc - dz;
                    acc = acc + ATAN_LUT[i];
                end
                else
                begin
                    xc  = xc - dx;
                    zc  = zc + dz;
                    acc = acc - ATAN_LUT[i];
                end
            end
            turn = 64'(acc);
            if (ANG_SHIFT > 0)
                turn = (turn + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
            res.angle = turn[COORD_WIDTH-1:0];
            if (xc < 0)
                xc = 0;
            mag = xc;
            mag = (mag * GAIN_RECIP_Q20 + (64'd1 << 19)) >> 20;
            rad = (mag * r_recip + (64'd1 << (7 + GUARD_BITS))) >> (8 + GUARD_BITS);
            if (rad > (64'd1 << COORD_WIDTH) - 1)
                rad = (64'd1 << COORD_WIDTH) - 1;
            res.radial = rad[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] extreme_value();
        case ($urandom_range(4, 0))
            0:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            1:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            2:       return '0;
            3:       return COORD_WIDTH'(1);
            default: return '1;
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.x = COORD_WIDTH'($urandom());
        p.y = COORD_WIDTH'($urandom());
        p.z = COORD_WIDTH'($urandom());
        case ($urandom_range(7, 0))
            0, 1:
            begin
                // Short vectors, where the floor shifts matter most.
                p.x = COORD_WIDTH'(int'($urandom_range(128, 0)) - 64);
                p.z = COORD_WIDTH'(int'($urandom_range(128, 0)) - 64);
            end
            2:
            begin
                if ($urandom_range(1, 0) == 1)
                    p.x = '0;
                else
                    p.z = '0;
            end
            3:
            begin
                p.x = extreme_value();
                p.y = extreme_value();
                p.z = extreme_value();
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic report_mismatch(string what, cyl_t want, cyl_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected axial %0d angle %0d radial %0d, %s %0d %s %0d %s %0d",
                     $time, what, want.axial, want.angle, want.radial,
                     "got axial", got.axial, "angle", got.angle,
                     "radial", got.radial);
    endtask

    // Result check first, then the prediction for a point taken at this edge.
    always @(posedge clk)
    begin
        cyl_t got;
        cyl_t want;
        got = cyl_t'{axial_fraction, angle, radial_fraction};
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_cyl_q.size() == 0)
                    report_mismatch("result without a pending point", '0, got);
                else
                begin
                    want = expected_cyl_q.pop_front();
                    if (got.axial !== want.axial || got.angle !== want.angle ||
                        got.radial !== want.radial)
                        report_mismatch("result mismatch", want, got);
                end
            end
            point_taken <= start && !busy;
            if (start && !busy)
                expected_cyl_q.push_back(to_cylinder(point_t'{x_coord, y_coord, z_coord},
                                                     height_recip, radius_recip));
        end
        else
            point_taken <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (point_taken)
                point_q.delete(0);
            if (point_q.size() > 0 && int'($urandom_range(99, 0)) >= send_idle_pct)
            begin
                start   <= 1'b1;
                x_coord <= point_q[0].x;
                y_coord <= point_q[0].y;
                z_coord <= point_q[0].z;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_drained();
        while (point_q.size() != 0 || expected_cyl_q.size() != 0 || start)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            IDX_INV_HEIGHT: height_recip = data;
            IDX_INV_RADIUS: radius_recip = data;
            default: ;
        endcase
    endtask

    // Registers change only once every pending point has come out.
    task automatic run_phase(logic [REG_W-1:0] h_recip, logic [REG_W-1:0] r_recip,
                             bit poke_spare, int idle_pct, int count);
        wait_drained();
        write_reg(IDX_INV_HEIGHT, h_recip);
        write_reg(IDX_INV_RADIUS, r_recip);
        if (poke_spare)
        begin
            write_reg(IDX_SPARE_LO, REG_W'($urandom()));
            write_reg(IDX_SPARE_HI, REG_W'($urandom()));
        end
        @(negedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        send_idle_pct = idle_pct;
        repeat (count)
            point_q.push_back(random_point());
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset register values with the directed points, back to back.
        @(posedge clk);
        send_idle_pct = 0;
        foreach (DIRECTED[k])
            point_q.push_back(DIRECTED[k]);

        run_phase('1, '1, 1'b0, 76, 150);
        run_phase(REG_W'(1), REG_W'(1), 1'b1, 0, 120);
        run_phase('0, '0, 1'b0, 26, 60);
        run_phase(REG_W'($urandom_range(65535, 1)), REG_W'($urandom_range(65535, 1)),
                  1'b1, 26, 180);
        run_phase(REG_W'(256), REG_W'(4096), 1'b0, 76, 120);
        run_phase(REG_W'($urandom()), REG_W'($urandom()), 1'b0, 0, 120);

        wait_drained();
        repeat (SETTLE_LIMIT) @(posedge clk);
        mismatch_count += expected_cyl_q.size();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
